// ===== hw/rtl/wsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_pkg
// Shared types, constants and tables for the waypoint steering guidance core.
// ----------------------------------------------------------------------------
package wsg_pkg;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_WAYPOINT = 2'd0;
  localparam logic [1:0] KIND_START    = 2'd1;
  localparam logic [1:0] KIND_POSE     = 2'd2;

  // Field widths.
  localparam int unsigned DIFF_W  = 26;  // waypoint minus position, 1/256 inch
  localparam int unsigned SQ_W    = 50;  // sum of squares and root datapath
  localparam int unsigned DIST_W  = 24;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned ROT_W   = 20;
  localparam int unsigned SPD_W   = 9;
  localparam int unsigned VEC_W   = 60;  // CORDIC vector components
  localparam int unsigned ACC_W   = 22;  // CORDIC angle, 2^-20 turn
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 25;

  // Steering constants.
  localparam logic [SPD_W-1:0]  SPEED_APPROACH = 9'd50;
  localparam logic [SPD_W-1:0]  SPEED_MAX      = 9'd500;
  localparam logic [SPD_W-1:0]  SPEED_RESET    = 9'd100;
  localparam logic [DIST_W-1:0] REACH_DIST     = 24'd256;   // 1 inch
  localparam logic [DIST_W-1:0] APPROACH_DIST  = 24'd1280;  // 5 inches
  localparam logic signed [ANG_W-1:0] SPIN_ERR     = 16'sd8192;  // 45 degrees
  localparam logic signed [ANG_W-1:0] DEADBAND_ERR = 16'sd364;   // 2 degrees
  localparam logic [ROT_W-1:0] RADIUS_LIMIT = 20'd399999;
  localparam logic [ROT_W-1:0] RADIUS_SAT   = 20'd400000;
  // ceil(2^27 / 15), exact floor division for values below 2^23.
  localparam logic [23:0] RECIP15 = 24'd8947849;
  localparam int unsigned RECIP_SHIFT = 27;

  // CORDIC arctangent steps, round(atan(2^-i) * 2^20 / (2 pi)).
  function automatic logic [17:0] atan_step(input logic [3:0] i);
    logic [17:0] r;
    unique case (i)
      4'd0:    r = 18'd131072;
      4'd1:    r = 18'd77376;
      4'd2:    r = 18'd40884;
      4'd3:    r = 18'd20753;
      4'd4:    r = 18'd10417;
      4'd5:    r = 18'd5213;
      4'd6:    r = 18'd2607;
      4'd7:    r = 18'd1304;
      4'd8:    r = 18'd652;
      4'd9:    r = 18'd326;
      4'd10:   r = 18'd163;
      4'd11:   r = 18'd81;
      4'd12:   r = 18'd41;
      4'd13:   r = 18'd20;
      4'd14:   r = 18'd10;
      default: r = 18'd5;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/wsg_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module wsg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire                              clk_i,
  input  wire                              we_i,
  input  wire [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  wire [WIDTH-1:0]                  wdata_i,
  input  wire                              re_i,
  input  wire [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/wsg_solver.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wsg_solver
// Iterative range and bearing unit: a bit-serial square root of dx^2 + dy^2
// and a vectoring CORDIC for atan2(dx, dy), both one step per cycle.
// ----------------------------------------------------------------------------
module wsg_solver (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                start_i,
  input  wire signed [wsg_pkg::DIFF_W-1:0]   dx_i,
  input  wire signed [wsg_pkg::DIFF_W-1:0]   dy_i,
  output logic                               done_o,
  output logic [wsg_pkg::DIST_W-1:0]         dist_o,
  output logic [wsg_pkg::ANG_W-1:0]          bearing_o
);
  import wsg_pkg::*;

  typedef enum logic [1:0] {P_IDLE, P_SUM, P_ITER} phase_e;

  phase_e                  phase_q;
  logic [4:0]              step_q;
  logic [SQ_W-1:0]         dxsq_q, dysq_q;
  logic [SQ_W-1:0]         rem_q, root_q, bit_q;
  logic signed [VEC_W-1:0] u_q, v_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    done_q;

  logic [SQ_W-1:0]         trial;
  logic signed [VEC_W-1:0] u0, v0, du, dv;
  logic signed [ACC_W-1:0] step_ang, acc_rnd;

  // Starting vector, turned by a half turn when it points below the x axis.
  assign u0 = VEC_W'(dy_i) <<< 30;
  assign v0 = VEC_W'(dx_i) <<< 30;

  // One square root step and one CORDIC step.
  assign trial    = root_q + bit_q;
  assign du       = v_q >>> step_q[3:0];
  assign dv       = u_q >>> step_q[3:0];
  assign step_ang = ACC_W'(atan_step(step_q[3:0]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            phase_q <= P_SUM;
          end
        end
        P_SUM: begin
          step_q  <= '0;
          phase_q <= P_ITER;
        end
        P_ITER: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'(SQRT_STEPS - 1)) begin
            phase_q <= P_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (phase_q == P_IDLE && start_i) begin
      dxsq_q <= unsigned'(SQ_W'(dx_i) * SQ_W'(dx_i));
      dysq_q <= unsigned'(SQ_W'(dy_i) * SQ_W'(dy_i));
      if (dy_i < 0) begin
        u_q   <= -u0;
        v_q   <= -v0;
        acc_q <= ACC_W'(524288);
      end else begin
        u_q   <= u0;
        v_q   <= v0;
        acc_q <= '0;
      end
    end else if (phase_q == P_SUM) begin
      rem_q  <= dxsq_q + dysq_q;
      root_q <= '0;
      bit_q  <= SQ_W'(1) << 48;
    end else if (phase_q == P_ITER) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (step_q < 5'(CORDIC_STEPS)) begin
        if (v_q >= 0) begin
          u_q   <= u_q + du;
          v_q   <= v_q - dv;
          acc_q <= acc_q + step_ang;
        end else begin
          u_q   <= u_q - du;
          v_q   <= v_q + dv;
          acc_q <= acc_q - step_ang;
        end
      end
    end
  end

  // Saturated distance and rounded 16-bit bearing.
  assign acc_rnd   = acc_q + ACC_W'(8);
  assign dist_o    = (root_q > SQ_W'(24'hFFFFFF)) ? 24'hFFFFFF : root_q[DIST_W-1:0];
  assign bearing_o = acc_rnd[19:4];
  assign done_o    = done_q;

endmodule
`default_nettype wire

// ===== hw/rtl/waypoint_steering_guidance_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_steering_guidance_core
// Waypoint-following guidance: keeps a waypoint table in RAM and turns each
// pose sample into distance, heading error, speed and turn-radius requests.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  kind, wp_index, wp_x, wp_y,
//                                            wp_count, pos_x, pos_y, theta
// out      output     out_valid_o/out_stall_i vel_request, rot_request,
//                                            mission_active, active_waypoint,
//                                            target_dist, heading_err
// cfg      input      cfg_valid_i/cfg_ready_o seek_speed
//
// Waypoint, start, unknown and disarmed pose items go from acceptance
// straight to S_OUT; the next item is taken once back in S_IDLE.
// An armed pose passes S_READ, S_DIFF, S_START, S_WAIT (the solver, mostly
// its 25-step square root), S_ERR, S_SCALE, S_RECIP, S_STEER and S_OUT;
// advancing to the next waypoint adds a second table read and solve, and
// reaching the last waypoint goes from S_ERR straight to S_OUT. One item is
// in work at a time; a finished result waits in the output register while
// the next item is taken; a full output register stalls the next result.
// Reset is asynchronous; the waypoint table is not cleared.
// ----------------------------------------------------------------------------
module waypoint_steering_guidance_core #(
  parameter int unsigned MAX_WAYPOINTS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  kind_i,
  input  wire  [3:0]  wp_index_i,
  input  wire  signed [15:0] wp_x_i,
  input  wire  signed [15:0] wp_y_i,
  input  wire  [4:0]  wp_count_i,
  input  wire  signed [23:0] pos_x_i,
  input  wire  signed [23:0] pos_y_i,
  input  wire  [15:0] theta_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [8:0]  vel_request_o,
  output logic signed [19:0] rot_request_o,
  output logic        mission_active_o,
  output logic [3:0]  active_waypoint_o,
  output logic [23:0] target_dist_o,
  output logic signed [15:0] heading_err_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [8:0]  cfg_data_i
);
  import wsg_pkg::*;

  localparam int unsigned IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DIFF, S_START, S_WAIT, S_ERR,
    S_SCALE, S_RECIP, S_STEER, S_OUT
  } state_e;

  state_e                    state_q;
  logic [SPD_W-1:0]          seek_q;
  logic [LEN_W-1:0]          len_q;
  logic [IDX_W-1:0]          cur_q;
  logic                      armed_q;
  logic                      pass_q;
  logic [ANG_W-1:0]          bearing_q;
  logic [SPD_W-1:0]          speed_q;
  logic signed [ROT_W-1:0]   rot_q;
  logic signed [23:0]        pos_x_q, pos_y_q;
  logic [ANG_W-1:0]          theta_q;
  logic signed [DIFF_W-1:0]  dx_q, dy_q;
  logic [DIST_W-1:0]         dist_q;
  logic signed [ANG_W-1:0]   err_q;
  logic [22:0]               scaled_q;
  logic [ROT_W-1:0]          radius_q;
  logic                      out_valid_q;

  logic                      in_xfer, out_free, wp_we, rd_en;
  logic [31:0]               rdata;
  logic [LEN_W-1:0]          len_clamped;
  logic                      solve_done;
  logic [DIST_W-1:0]         solve_dist;
  logic [ANG_W-1:0]          solve_bearing;
  logic [DIST_W+6:0]         dist_x127;
  logic [46:0]               recip_prod;
  logic [SPD_W-1:0]          seek_sat;
  logic [ROT_W-1:0]          mag;
  logic                      last_wp;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign wp_we       = in_xfer && (kind_i == KIND_WAYPOINT) &&
                       (32'(wp_index_i) < MAX_WAYPOINTS);
  assign rd_en       = (state_q == S_READ);

  // Waypoint table: x in the upper half, y in the lower half.
  wsg_ram #(
    .WIDTH(32),
    .DEPTH(MAX_WAYPOINTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wp_we),
    .waddr_i(IDX_W'(wp_index_i)),
    .wdata_i({wp_x_i, wp_y_i}),
    .re_i   (rd_en),
    .raddr_i(cur_q),
    .rdata_o(rdata)
  );

  // Range and bearing solver.
  wsg_solver u_solver (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (state_q == S_START),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .done_o   (solve_done),
    .dist_o   (solve_dist),
    .bearing_o(solve_bearing)
  );

  // Course length clamped to one through the table depth.
  always_comb begin
    if (wp_count_i == 5'd0) begin
      len_clamped = LEN_W'(1);
    end else if (32'(wp_count_i) > MAX_WAYPOINTS) begin
      len_clamped = LEN_W'(MAX_WAYPOINTS);
    end else begin
      len_clamped = LEN_W'(wp_count_i);
    end
  end

  // Steering arithmetic helpers.
  assign last_wp    = (32'(cur_q) + 32'd1) >= 32'(len_q);
  assign dist_x127  = (DIST_W+7)'(dist_q) * (DIST_W+7)'(127);
  assign recip_prod = 47'(scaled_q) * 47'(RECIP15);
  assign seek_sat   = (seek_q > SPEED_MAX) ? SPEED_MAX : seek_q;
  assign mag        = (radius_q >= RADIUS_LIMIT) ? RADIUS_SAT : radius_q + 20'd1;

  // Sequencer with guidance state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seek_q      <= SPEED_RESET;
      len_q       <= LEN_W'(1);
      cur_q       <= '0;
      armed_q     <= 1'b0;
      pass_q      <= 1'b0;
      bearing_q   <= '0;
      speed_q     <= SPEED_RESET;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        seek_q <= cfg_data_i;
      end
      // The output register fills from S_OUT and drains on a result transfer.
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (kind_i == KIND_START) begin
              len_q   <= len_clamped;
              cur_q   <= '0;
              armed_q <= 1'b1;
            end
            pass_q <= 1'b0;
            if (kind_i == KIND_POSE && armed_q) begin
              state_q <= S_READ;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_READ:  state_q <= S_DIFF;
        S_DIFF:  state_q <= S_START;
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (solve_done) begin
            if (dx_q != '0) begin
              bearing_q <= solve_bearing;
            end
            state_q <= S_ERR;
          end
        end
        S_ERR: begin
          if (!pass_q && dist_q < REACH_DIST) begin
            if (last_wp) begin
              armed_q <= 1'b0;
              state_q <= S_OUT;
            end else begin
              cur_q   <= cur_q + IDX_W'(1);
              pass_q  <= 1'b1;
              state_q <= S_READ;
            end
          end else begin
            state_q <= S_SCALE;
          end
        end
        S_SCALE: state_q <= S_RECIP;
        S_RECIP: state_q <= S_STEER;
        S_STEER: begin
          speed_q <= (dist_q < APPROACH_DIST) ? SPEED_APPROACH : seek_sat;
          priority if (err_q >= SPIN_ERR) begin
            rot_q <= -20'sd1;
          end else if (err_q <= -SPIN_ERR) begin
            rot_q <= 20'sd1;
          end else if (err_q > DEADBAND_ERR) begin
            rot_q <= -$signed(mag);
          end else if (err_q < -DEADBAND_ERR) begin
            rot_q <= $signed(mag);
          end else begin
            rot_q <= '0;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      theta_q <= theta_i;
      dist_q  <= '0;
      err_q   <= '0;
    end
    if (state_q == S_DIFF) begin
      dx_q <= $signed({{2{rdata[31]}}, rdata[31:16], 8'h00}) -
              $signed({{2{pos_x_q[23]}}, pos_x_q});
      dy_q <= $signed({{2{rdata[15]}}, rdata[15:0], 8'h00}) -
              $signed({{2{pos_y_q[23]}}, pos_y_q});
    end
    if (state_q == S_WAIT && solve_done) begin
      dist_q <= solve_dist;
    end
    if (state_q == S_ERR) begin
      err_q <= $signed(bearing_q - theta_q);
    end
    if (state_q == S_SCALE) begin
      scaled_q <= dist_x127[DIST_W+6:8];
    end
    if (state_q == S_RECIP) begin
      radius_q <= recip_prod[46:RECIP_SHIFT];
    end
    if (state_q == S_OUT && out_free) begin
      vel_request_o     <= speed_q;
      rot_request_o     <= rot_q;
      mission_active_o  <= armed_q;
      active_waypoint_o <= 4'(32'(cur_q));
      target_dist_o     <= dist_q;
      heading_err_o     <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
